/* design/shuffled_lcg_uniform_generator_assert.svh */
// ----------------------------------------------------------------------------
// Assertion macros for the shuffled LCG uniform generator
// Shared concurrent assertion forms used by the controller and datapath.
// ----------------------------------------------------------------------------
`ifndef SHUFFLED_LCG_UNIFORM_GENERATOR_ASSERT_SVH
`define SHUFFLED_LCG_UNIFORM_GENERATOR_ASSERT_SVH

// Same-cycle implication
`define SLCG_ASSERT_IMP(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("slcg: same-cycle check failed");

// Next-cycle implication
`define SLCG_ASSERT_NXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("slcg: next-cycle check failed");

`endif

/* design/slcg_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// slcg_pkg
// Constants and controller/datapath interface types of the shuffled
// minimal-standard uniform generator.
// ----------------------------------------------------------------------------
package slcg_pkg;

   localparam int VALUE_W = 31;
   localparam int FRAC_W  = 24;
   localparam int MULT_W  = 15;

   // Park-Miller multiplier and modulus 2^31-1
   localparam logic [MULT_W-1:0]  MS_MULT  = 15'd16807;
   localparam logic [VALUE_W-1:0] MS_MOD   = 31'h7FFF_FFFF;
   // Q0.24 clamp for an all-ones fraction, one step below the largest value
   localparam logic [FRAC_W-1:0]  FRAC_MAX = 24'd16777214;

   // controller -> datapath commands
   typedef struct packed {
      logic seed_load;   // load generator from seed, start warm-up count
      logic step_mul;    // generator product register
      logic slot_mul;    // reciprocal product for slot index
      logic step_red;    // fold product mod 2^31-1 into generator
      logic warm_fill;   // warm-up table write and count down
      logic slot_read;   // issue table read at slot index
      logic commit;      // update held value, table slot and output register
   } cmd_type;

   // datapath -> controller status
   typedef struct packed {
      logic held_zero;
      logic gen_zero;
      logic count_zero;
      logic out_free;
   } status_type;

endpackage

/* design/slcg_ram.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// slcg_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module slcg_ram #(
   parameter int WIDTH = 31,
   parameter int DEPTH = 32,
   localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [WIDTH-1:0]  wr_data,
   input  logic              rd_en,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // storage array and registered read port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

/* design/slcg_ctrl.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// slcg_ctrl
// Sequencer for reseed/warm-up and draw transactions.
// ----------------------------------------------------------------------------
`include "shuffled_lcg_uniform_generator_assert.svh"

module slcg_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   input  logic                   restart,
   output logic                   req_ready,
   input  slcg_pkg::status_type   status,
   output slcg_pkg::cmd_type      cmd
);

   typedef enum logic [6:0] {
      ST_IDLE = 7'b0000001,
      ST_SEED = 7'b0000010,
      ST_WMUL = 7'b0000100,
      ST_WRED = 7'b0001000,
      ST_DMUL = 7'b0010000,
      ST_DRED = 7'b0100000,
      ST_DWR  = 7'b1000000
   } state_type;

   state_type state_ff, state_in;
   logic      need_warm;

   assign req_ready = (state_ff == ST_IDLE);
   // reseed on request, or when never seeded / generator dead
   assign need_warm = restart | status.held_zero | status.gen_zero;

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               state_in = need_warm ? ST_SEED : ST_DMUL;
            end
         end
         ST_SEED: state_in = ST_WMUL;
         ST_WMUL: state_in = ST_WRED;
         ST_WRED: begin
            state_in = status.count_zero ? ST_DMUL : ST_WMUL;
         end
         ST_DMUL: state_in = ST_DRED;
         ST_DRED: state_in = ST_DWR;
         ST_DWR: begin
            if (status.out_free) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // command decode
   always_comb begin
      cmd = '0;
      case (state_ff)
         ST_SEED: cmd.seed_load = 1'b1;
         ST_WMUL: cmd.step_mul  = 1'b1;
         ST_WRED: begin
            cmd.step_red  = 1'b1;
            cmd.warm_fill = 1'b1;
         end
         ST_DMUL: begin
            cmd.step_mul = 1'b1;
            cmd.slot_mul = 1'b1;
         end
         ST_DRED: begin
            cmd.step_red  = 1'b1;
            cmd.slot_read = 1'b1;
         end
         ST_DWR:  cmd.commit = status.out_free;
         default: cmd = '0;
      endcase
   end

   // state register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // assertions
   `SLCG_ASSERT_NXT(a_warm_entry, clock, reset, req_ready && req_valid && need_warm, state_ff == ST_SEED)
   `SLCG_ASSERT_NXT(a_plain_entry, clock, reset, req_ready && req_valid && !need_warm, state_ff == ST_DMUL)
   `SLCG_ASSERT_NXT(a_warm_exit, clock, reset, cmd.warm_fill && status.count_zero, state_ff == ST_DMUL)

endmodule

/* design/slcg_datapath.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// slcg_datapath
// Generator step (multiply, fold mod 2^31-1), slot index by reciprocal
// multiply, shuffle table and output register.
// ----------------------------------------------------------------------------
`include "shuffled_lcg_uniform_generator_assert.svh"

module slcg_datapath #(
   parameter int TABLE_DEPTH = 32
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 csr_valid,
   input  logic [slcg_pkg::VALUE_W-1:0]         csr_wdata,
   input  slcg_pkg::cmd_type                    cmd,
   output slcg_pkg::status_type                 status,
   input  logic                                 rsp_tready,
   output logic                                 rsp_tvalid,
   output logic [slcg_pkg::VALUE_W-1:0]         rsp_raw,
   output logic [slcg_pkg::FRAC_W-1:0]          rsp_frac
);

   localparam int VW     = slcg_pkg::VALUE_W;
   localparam int PROD_W = VW + slcg_pkg::MULT_W;
   localparam int AW     = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
   localparam int QW     = AW + 1;
   localparam int CNT_W  = $clog2(TABLE_DEPTH + 8);

   // slot = held / SLOT_DIV, done as exact reciprocal multiply and shift
   localparam logic [63:0] SLOT_DIV   = 64'd1 + (64'(slcg_pkg::MS_MOD) - 64'd1)
                                               / 64'(TABLE_DEPTH);
   localparam int          SLOT_LOG   = $clog2(SLOT_DIV);
   localparam int          SLOT_SHIFT = VW + SLOT_LOG;
   localparam logic [31:0] SLOT_MULT  = 32'(((64'd1 << SLOT_SHIFT) + SLOT_DIV - 64'd1)
                                               / SLOT_DIV);

   logic [VW-1:0]     seed_ff;
   logic [VW-1:0]     gen_ff, gen_in;
   logic [VW-1:0]     held_ff, held_in;
   logic [PROD_W-1:0] prod_ff;
   logic [63:0]       recip_ff;
   logic [CNT_W-1:0]  count_ff, count_in;
   logic [AW-1:0]     slot_ff;
   logic              rsp_valid_ff, rsp_valid_in;
   logic [VW-1:0]     out_raw_ff;
   logic [slcg_pkg::FRAC_W-1:0] out_frac_ff, frac_val;

   logic [VW:0]       fold_sum;
   logic [VW-1:0]     gen_red;
   logic [QW-1:0]     slot_quot;
   logic [AW-1:0]     slot_idx;
   logic              count_in_table;
   logic              ram_wr_en;
   logic [AW-1:0]     ram_wr_addr;
   logic [VW-1:0]     ram_wr_data;
   logic [VW-1:0]     ram_rd_data;

   // seed register; the user must write it only while idle, which the block does not enforce
   always_ff @(posedge clock) begin
      if (reset) begin
         seed_ff <= {{(VW-1){1'b0}}, 1'b1};
      end else if (csr_valid) begin
         seed_ff <= csr_wdata;
      end
   end

   // 2^31 == 1 mod (2^31-1): fold high part onto low part, one correction
   assign fold_sum = {1'b0, prod_ff[VW-1:0]}
                   + {{(VW+1-slcg_pkg::MULT_W){1'b0}}, prod_ff[PROD_W-1:VW]};
   assign gen_red  = (fold_sum >= {1'b0, slcg_pkg::MS_MOD})
                   ? VW'(fold_sum - {1'b0, slcg_pkg::MS_MOD})
                   : fold_sum[VW-1:0];

   // slot index, clamped to the table
   assign slot_quot = recip_ff[SLOT_SHIFT +: QW];
   assign slot_idx  = (slot_quot > QW'(TABLE_DEPTH - 1)) ? AW'(TABLE_DEPTH - 1)
                                                        : slot_quot[AW-1:0];

   assign count_in_table = (32'(count_ff) < TABLE_DEPTH);

   // generator, held value and warm-up counter
   always_comb begin
      gen_in   = gen_ff;
      held_in  = held_ff;
      count_in = count_ff;
      if (cmd.seed_load) begin
         gen_in   = (seed_ff == '0) ? {{(VW-1){1'b0}}, 1'b1} : seed_ff;
         count_in = CNT_W'(TABLE_DEPTH + 7);
      end
      if (cmd.step_red) begin
         gen_in = gen_red;
      end
      if (cmd.warm_fill) begin
         count_in = count_ff - 1'b1;
         if (count_ff == '0) begin
            held_in = gen_red;
         end
      end
      if (cmd.commit) begin
         held_in = ram_rd_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         gen_ff  <= '0;
         held_ff <= '0;
      end else begin
         gen_ff  <= gen_in;
         held_ff <= held_in;
      end
   end

   // products and working registers
   always_ff @(posedge clock) begin
      count_ff <= count_in;
      if (cmd.step_mul) begin
         prod_ff <= {{slcg_pkg::MULT_W{1'b0}}, gen_ff}
                  * {{VW{1'b0}}, slcg_pkg::MS_MULT};
      end
      if (cmd.slot_mul) begin
         recip_ff <= {33'd0, held_ff} * {32'd0, SLOT_MULT};
      end
      if (cmd.slot_read) begin
         slot_ff <= slot_idx;
      end
   end

   // shuffle table port muxing
   always_comb begin
      ram_wr_en   = 1'b0;
      ram_wr_addr = slot_ff;
      ram_wr_data = gen_ff;
      if (cmd.warm_fill) begin
         ram_wr_en   = count_in_table;
         ram_wr_addr = count_ff[AW-1:0];
         ram_wr_data = gen_red;
      end else if (cmd.commit) begin
         ram_wr_en = 1'b1;
      end
   end

   slcg_ram #(
      .WIDTH (VW),
      .DEPTH (TABLE_DEPTH)
   ) u_table (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_en   (cmd.slot_read),
      .rd_addr (slot_idx),
      .rd_data (ram_rd_data)
   );

   // Q0.24 fraction, all-ones value clamped to FRAC_MAX
   assign frac_val = (ram_rd_data[VW-1:7] == '1) ? slcg_pkg::FRAC_MAX
                                                 : ram_rd_data[VW-1:7];

   // output register
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd.commit) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.commit) begin
         out_raw_ff  <= ram_rd_data;
         out_frac_ff <= frac_val;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_raw    = out_raw_ff;
   assign rsp_frac   = out_frac_ff;

   assign status.held_zero  = (held_ff == '0);
   assign status.gen_zero   = (gen_ff == '0);
   assign status.count_zero = (count_ff == '0);
   assign status.out_free   = !rsp_valid_ff || rsp_tready;

   // assertions
   `SLCG_ASSERT_NXT(a_gen_reduced, clock, reset, cmd.step_red, gen_ff != slcg_pkg::MS_MOD)
   `SLCG_ASSERT_NXT(a_warm_held, clock, reset, cmd.warm_fill && status.count_zero, held_ff == gen_ff)
   `SLCG_ASSERT_NXT(a_slot_range, clock, reset, cmd.slot_read, 32'(slot_ff) < TABLE_DEPTH)

endmodule

/* design/shuffled_lcg_uniform_generator.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// shuffled_lcg_uniform_generator
// Minimal-standard generator (16807 * x mod 2^31-1) with a Bays-Durham
// shuffle table; one uniform draw per request transaction.
// ----------------------------------------------------------------------------
//  channel  direction  handshake             payload
//  req      in         req_tvalid/tready     tdata[0] restart
//  rsp      out        rsp_tvalid/tready     tdata[30:0] raw, [54:31] fraction
//  csr      in         csr_valid/ready       csr_wdata seed magnitude
//
//  Plain draw: after accept the sequence runs multiply, fold + table read,
//  then table write-back, using the shared generator multiplier and the
//  registered table read; no new request is taken until it returns to idle.
//  Reseed: adds a seed load, then TABLE_DEPTH+8 generator steps, each a
//  multiply then a fold through the same multiply/fold unit.
//  Reset: synchronous; seed returns to 1 and the next draw reseeds. The
//  table needs no clearing.
//  Stalls: a result waits in the output register; the next request is taken
//  meanwhile and only its write-back waits for rsp_tready.
// ----------------------------------------------------------------------------
module shuffled_lcg_uniform_generator #(
   parameter int TABLE_DEPTH = 32
) (
   input  logic        clock,
   input  logic        reset,
   // request stream
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [0] restart, [7:1] zero
   // result stream
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [55:0] rsp_tdata,   // [30:0] raw_value, [54:31] fraction, [55] zero
   // seed register write
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [30:0] csr_wdata
);

   slcg_pkg::cmd_type    cmd;
   slcg_pkg::status_type status;
   logic [slcg_pkg::VALUE_W-1:0] rsp_raw;
   logic [slcg_pkg::FRAC_W-1:0]  rsp_frac;

   assign csr_ready = 1'b1;

   slcg_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_tvalid),
      .restart   (req_tdata[0]),
      .req_ready (req_tready),
      .status    (status),
      .cmd       (cmd)
   );

   slcg_datapath #(
      .TABLE_DEPTH (TABLE_DEPTH)
   ) u_datapath (
      .clock      (clock),
      .reset      (reset),
      .csr_valid  (csr_valid),
      .csr_wdata  (csr_wdata),
      .cmd        (cmd),
      .status     (status),
      .rsp_tready (rsp_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_raw    (rsp_raw),
      .rsp_frac   (rsp_frac)
   );

   assign rsp_tdata = {1'b0, rsp_frac, rsp_raw};

endmodule
